// ===== design/sfr_pkg.sv =====
// Shared types and constants for the stuffed frame receiver.
`default_nettype none

package sfr_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h7E;
  localparam logic [7:0] ADDR_BYTE = 8'h03;
  localparam logic [7:0] CTRL_SEQ0 = 8'h00;
  localparam logic [7:0] CTRL_SEQ1 = 8'h40;
  localparam logic [7:0] ESC_BYTE  = 8'h7D;
  localparam logic [7:0] ESC_FLAG  = 8'h5E;
  localparam logic [7:0] ESC_ESC   = 8'h5D;
  localparam logic [7:0] RR_SEQ0   = 8'h05;
  localparam logic [7:0] RR_SEQ1   = 8'h85;
  localparam logic [7:0] REJ_SEQ0  = 8'h01;
  localparam logic [7:0] REJ_SEQ1  = 8'h81;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_ADDR = 3'd1;
  localparam logic [2:0] PH_CTRL = 3'd2;
  localparam logic [2:0] PH_HCHK = 3'd3;
  localparam logic [2:0] PH_BODY = 3'd4;
  localparam logic [2:0] PH_ESC  = 3'd5;

  localparam logic [1:0] V_NEW    = 2'd0;
  localparam logic [1:0] V_DUP    = 2'd1;
  localparam logic [1:0] V_BADCHK = 2'd2;
  localparam logic [1:0] V_BADESC = 2'd3;

  localparam logic KIND_PAYLOAD = 1'b0;
  localparam logic KIND_VERDICT = 1'b1;

  typedef struct packed {
    logic       result_kind;
    logic [7:0] payload_byte;
    logic [1:0] verdict;
    logic [7:0] reply_control;
    logic       frame_sequence;
  } result_t;

endpackage

`default_nettype wire

// ===== design/stuffed_frame_receiver.sv =====
// Top level of the byte-stuffed frame receiver.
//
//   channel | valid     | stall     | payload
//   input   | in_valid  | in_stall  | rx_byte
//   output  | out_valid | out_stall | result_kind, payload_byte, verdict,
//           |           |           | reply_control, frame_sequence
//
// One line byte per cycle sustained while the output is not stalled; a byte passes the input
// register, then its result, if any, the result register.
// Frame state updates in one pass of compare/XOR logic between the two registers.
// rst is synchronous; it clears both stages and the frame state, hunting for a flag.
// A stalled output holds the result register and backs up into in_stall.
`default_nettype none

module stuffed_frame_receiver (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            result_kind,
  output logic [7:0]      payload_byte,
  output logic [1:0]      verdict,
  output logic [7:0]      reply_control,
  output logic            frame_sequence
);

  logic             advance;
  logic             held;
  logic [7:0]       held_rx;
  logic             fire;
  logic             res_valid;
  sfr_pkg::result_t res;

  assign fire = held && advance;

  sfr_in_stage u_in (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .rx_byte  (rx_byte),
    .advance  (advance),
    .held     (held),
    .held_rx  (held_rx)
  );

  sfr_engine u_engine (
    .clk       (clk),
    .rst       (rst),
    .fire      (fire),
    .c         (held_rx),
    .res_valid (res_valid),
    .res       (res)
  );

  sfr_out_stage u_out (
    .clk            (clk),
    .rst            (rst),
    .fire           (fire),
    .res_valid      (res_valid),
    .res            (res),
    .advance        (advance),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .result_kind    (result_kind),
    .payload_byte   (payload_byte),
    .verdict        (verdict),
    .reply_control  (reply_control),
    .frame_sequence (frame_sequence)
  );

endmodule

`default_nettype wire

// ===== design/sfr_in_stage.sv =====
// Input register stage for received line bytes.
`default_nettype none

module sfr_in_stage (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] rx_byte,
  input  wire logic       advance,
  output logic            held,
  output logic [7:0]      held_rx
);

  logic       valid1;
  logic [7:0] byte1;

  assign in_stall = valid1 && !advance;
  assign held     = valid1;
  assign held_rx  = byte1;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid1 <= 1'b0;
    end else if (!in_stall) begin
      valid1 <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      byte1 <= rx_byte;
    end
  end

endmodule

`default_nettype wire

// ===== design/sfr_engine.sv =====
// Frame state machine: header hunt, destuffing, trailer check and verdict.
`default_nettype none

module sfr_engine (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       fire,
  input  wire logic [7:0] c,
  output logic            res_valid,
  output sfr_pkg::result_t res
);

  logic [2:0] phase, phase_next;
  logic       received_sequence, received_sequence_next;
  logic [7:0] running_parity, running_parity_next;
  logic [7:0] held_byte, held_byte_next;
  logic       held_valid, held_valid_next;
  logic       expected_sequence, expected_sequence_next;

  always_comb begin
    logic [7:0] data;
    logic       take_data;
    logic       give_verdict;
    logic       positive;
    logic [1:0] vcode;
    logic [7:0] hdr_chk;

    data        = c;
    take_data   = 1'b0;
    give_verdict = 1'b0;
    positive    = 1'b0;
    vcode       = sfr_pkg::V_NEW;
    hdr_chk     = sfr_pkg::ADDR_BYTE ^
                  (received_sequence ? sfr_pkg::CTRL_SEQ1 : sfr_pkg::CTRL_SEQ0);

    phase_next             = phase;
    received_sequence_next = received_sequence;
    running_parity_next    = running_parity;
    held_byte_next         = held_byte;
    held_valid_next        = held_valid;
    expected_sequence_next = expected_sequence;
    res_valid              = 1'b0;
    res                    = '0;

    case (phase)
      sfr_pkg::PH_HUNT: begin
        if (c == sfr_pkg::FLAG_BYTE) phase_next = sfr_pkg::PH_ADDR;
      end
      sfr_pkg::PH_ADDR: begin
        if (c == sfr_pkg::ADDR_BYTE) phase_next = sfr_pkg::PH_CTRL;
        else if (c != sfr_pkg::FLAG_BYTE) phase_next = sfr_pkg::PH_HUNT;
      end
      sfr_pkg::PH_CTRL: begin
        if (c == sfr_pkg::CTRL_SEQ0 || c == sfr_pkg::CTRL_SEQ1) begin
          received_sequence_next = (c == sfr_pkg::CTRL_SEQ1);
          phase_next = sfr_pkg::PH_HCHK;
        end else if (c == sfr_pkg::FLAG_BYTE) begin
          phase_next = sfr_pkg::PH_ADDR;
        end else begin
          phase_next = sfr_pkg::PH_HUNT;
        end
      end
      sfr_pkg::PH_HCHK: begin
        if (c == hdr_chk) begin
          running_parity_next = '0;
          held_valid_next     = 1'b0;
          phase_next          = sfr_pkg::PH_BODY;
        end else begin
          phase_next = sfr_pkg::PH_HUNT;
        end
      end
      sfr_pkg::PH_BODY: begin
        if (c == sfr_pkg::FLAG_BYTE) begin
          give_verdict = 1'b1;
          if (!held_valid || held_byte != running_parity) begin
            vcode = sfr_pkg::V_BADCHK;
          end else if (received_sequence == expected_sequence) begin
            expected_sequence_next = !expected_sequence;
            vcode    = sfr_pkg::V_NEW;
            positive = 1'b1;
          end else begin
            vcode    = sfr_pkg::V_DUP;
            positive = 1'b1;
          end
        end else if (c == sfr_pkg::ESC_BYTE) begin
          phase_next = sfr_pkg::PH_ESC;
        end else begin
          take_data = 1'b1;
        end
      end
      sfr_pkg::PH_ESC: begin
        if (c == sfr_pkg::ESC_FLAG) begin
          phase_next = sfr_pkg::PH_BODY;
          data       = sfr_pkg::FLAG_BYTE;
          take_data  = 1'b1;
        end else if (c == sfr_pkg::ESC_ESC) begin
          phase_next = sfr_pkg::PH_BODY;
          data       = sfr_pkg::ESC_BYTE;
          take_data  = 1'b1;
        end else begin
          give_verdict = 1'b1;
          vcode        = sfr_pkg::V_BADESC;
        end
      end
      default: begin
        phase_next = sfr_pkg::PH_HUNT;
      end
    endcase

    if (take_data) begin
      if (held_valid) begin
        res_valid            = 1'b1;
        res.result_kind      = sfr_pkg::KIND_PAYLOAD;
        res.payload_byte     = held_byte;
        running_parity_next  = running_parity ^ held_byte;
      end
      held_byte_next  = data;
      held_valid_next = 1'b1;
    end

    if (give_verdict) begin
      res_valid          = 1'b1;
      res.result_kind    = sfr_pkg::KIND_VERDICT;
      res.verdict        = vcode;
      res.frame_sequence = received_sequence;
      if (positive) begin
        res.reply_control = received_sequence ? sfr_pkg::RR_SEQ0 : sfr_pkg::RR_SEQ1;
      end else begin
        res.reply_control = received_sequence ? sfr_pkg::REJ_SEQ0 : sfr_pkg::REJ_SEQ1;
      end
      phase_next = sfr_pkg::PH_HUNT;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= sfr_pkg::PH_HUNT;
      received_sequence <= 1'b0;
      running_parity    <= '0;
      held_valid        <= 1'b0;
      expected_sequence <= 1'b0;
    end else if (fire) begin
      phase             <= phase_next;
      received_sequence <= received_sequence_next;
      running_parity    <= running_parity_next;
      held_valid        <= held_valid_next;
      expected_sequence <= expected_sequence_next;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      held_byte <= held_byte_next;
    end
  end

  // verdict always ends the frame
  a_verdict_hunt: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.result_kind == sfr_pkg::KIND_VERDICT)
      |=> phase == sfr_pkg::PH_HUNT)
    else $error("frame not closed after verdict");

  // expected sequence only moves on a new good frame
  a_seq_toggle: assert property (@(posedge clk) disable iff (rst)
    !(fire && res_valid && res.result_kind == sfr_pkg::KIND_VERDICT &&
      res.verdict == sfr_pkg::V_NEW) |=> $stable(expected_sequence))
    else $error("expected sequence moved without a new frame");

  // header check either drops the frame or opens an empty body
  a_body_open: assert property (@(posedge clk) disable iff (rst)
    (fire && phase == sfr_pkg::PH_HCHK) |=> (phase == sfr_pkg::PH_HUNT ||
      (phase == sfr_pkg::PH_BODY && !held_valid && running_parity == 8'h00)))
    else $error("body opened with stale state");

  // payload results only come from body bytes
  a_payload_src: assert property (@(posedge clk) disable iff (rst)
    (fire && res_valid && res.result_kind == sfr_pkg::KIND_PAYLOAD)
      |=> held_valid && (phase == sfr_pkg::PH_BODY))
    else $error("payload emitted outside the body");

endmodule

`default_nettype wire

// ===== design/sfr_out_stage.sv =====
// Result register driving the output channel.
`default_nettype none

module sfr_out_stage (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             fire,
  input  wire logic             res_valid,
  input  wire sfr_pkg::result_t res,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output logic                  result_kind,
  output logic [7:0]            payload_byte,
  output logic [1:0]            verdict,
  output logic [7:0]            reply_control,
  output logic                  frame_sequence
);

  logic             valid2;
  sfr_pkg::result_t res2;

  assign advance        = !valid2 || !out_stall;
  assign out_valid      = valid2;
  assign result_kind    = res2.result_kind;
  assign payload_byte   = res2.payload_byte;
  assign verdict        = res2.verdict;
  assign reply_control  = res2.reply_control;
  assign frame_sequence = res2.frame_sequence;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid2 <= 1'b0;
    end else if (advance) begin
      valid2 <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && fire && res_valid) begin
      res2 <= res;
    end
  end

endmodule

`default_nettype wire

// ===== tb/sv/frame_result_checker.sv =====
// Result checker: predicts the receiver's output from the accepted line bytes and compares.
`timescale 1ns / 1ps

module frame_result_checker
  import sfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] rx_byte,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       result_kind,
  input  logic [7:0] payload_byte,
  input  logic [1:0] verdict,
  input  logic [7:0] reply_control,
  input  logic       frame_sequence,
  output int         mismatches,
  output int         outstanding,
  output int         results_checked,
  output int         verdicts_checked
);

  logic [2:0] phase;
  logic       rx_seq;
  logic [7:0] body_xor;
  logic [7:0] pending_byte;
  logic       pending_ok;
  logic       next_seq;

  result_t frame_results_due[$];
  result_t seen;
  result_t want;

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] exp);
    $display("%0t ns: %s: got %02h, expected %02h", $time, what, got, exp);
    mismatches++;
  endtask

  task automatic take_body_byte(input logic [7:0] d);
    result_t r;
    if (pending_ok) begin
      r = '0;
      r.result_kind = KIND_PAYLOAD;
      r.payload_byte = pending_byte;
      frame_results_due.push_back(r);
      body_xor = body_xor ^ pending_byte;
    end
    pending_byte = d;
    pending_ok = 1'b1;
  endtask

  task automatic close_frame(input logic [1:0] v, input logic positive);
    result_t r;
    r = '0;
    r.result_kind = KIND_VERDICT;
    r.verdict = v;
    if (positive) r.reply_control = rx_seq ? RR_SEQ0 : RR_SEQ1;
    else r.reply_control = rx_seq ? REJ_SEQ0 : REJ_SEQ1;
    r.frame_sequence = rx_seq;
    frame_results_due.push_back(r);
    phase = PH_HUNT;
  endtask

  task automatic decode_line_byte(input logic [7:0] c);
    case (phase)
      PH_HUNT: begin
        if (c == FLAG_BYTE) phase = PH_ADDR;
      end
      PH_ADDR: begin
        if (c == ADDR_BYTE) phase = PH_CTRL;
        else if (c != FLAG_BYTE) phase = PH_HUNT;
      end
      PH_CTRL: begin
        if (c == CTRL_SEQ0 || c == CTRL_SEQ1) begin
          rx_seq = (c == CTRL_SEQ1);
          phase = PH_HCHK;
        end else if (c == FLAG_BYTE) begin
          phase = PH_ADDR;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_HCHK: begin
        if (c == (ADDR_BYTE ^ (rx_seq ? CTRL_SEQ1 : CTRL_SEQ0))) begin
          body_xor = 8'h00;
          pending_ok = 1'b0;
          phase = PH_BODY;
        end else begin
          phase = PH_HUNT;
        end
      end
      PH_BODY: begin
        if (c == FLAG_BYTE) begin
          if (!pending_ok || pending_byte != body_xor) begin
            close_frame(V_BADCHK, 1'b0);
          end else if (rx_seq == next_seq) begin
            next_seq = ~next_seq;
            close_frame(V_NEW, 1'b1);
          end else begin
            close_frame(V_DUP, 1'b1);
          end
        end else if (c == ESC_BYTE) begin
          phase = PH_ESC;
        end else begin
          take_body_byte(c);
        end
      end
      PH_ESC: begin
        if (c == ESC_FLAG) begin
          phase = PH_BODY;
          take_body_byte(FLAG_BYTE);
        end else if (c == ESC_ESC) begin
          phase = PH_BODY;
          take_body_byte(ESC_BYTE);
        end else begin
          close_frame(V_BADESC, 1'b0);
        end
      end
      default: begin
        phase = PH_HUNT;
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      phase = PH_HUNT;
      rx_seq = 1'b0;
      body_xor = 8'h00;
      pending_byte = 8'h00;
      pending_ok = 1'b0;
      next_seq = 1'b0;
      frame_results_due.delete();
    end else begin
      if (out_valid && !out_stall) begin
        seen = {result_kind, payload_byte, verdict, reply_control, frame_sequence};
        if (frame_results_due.size() == 0) begin
          report_mismatch("result with nothing expected", seen.payload_byte, 8'h00);
        end else begin
          want = frame_results_due.pop_front();
          if (seen.result_kind !== want.result_kind)
            report_mismatch("result_kind", seen.result_kind, want.result_kind);
          if (seen.payload_byte !== want.payload_byte)
            report_mismatch("payload_byte", seen.payload_byte, want.payload_byte);
          if (seen.verdict !== want.verdict)
            report_mismatch("verdict", seen.verdict, want.verdict);
          if (seen.reply_control !== want.reply_control)
            report_mismatch("reply_control", seen.reply_control, want.reply_control);
          if (seen.frame_sequence !== want.frame_sequence)
            report_mismatch("frame_sequence", seen.frame_sequence, want.frame_sequence);
          results_checked++;
          if (want.result_kind == KIND_VERDICT) verdicts_checked++;
        end
      end
      if (in_valid && !in_stall) decode_line_byte(rx_byte);
    end
    outstanding = frame_results_due.size();
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Testbench top: sends framed line bytes into the stuffed frame receiver and gives the verdict.
`timescale 1ns / 1ps

module testbench;
  import sfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TOTAL_BYTES = 1900;
  localparam int QUIET_AFTER = 1650;

  typedef enum int {
    FRM_GOOD,
    FRM_BAD_TRAILER,
    FRM_EMPTY,
    FRM_SINGLE,
    FRM_BAD_ESCAPE,
    FRM_BAD_HEADER,
    FRM_NOISE
  } frame_kind_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       result_kind;
  logic [7:0] payload_byte;
  logic [1:0] verdict;
  logic [7:0] reply_control;
  logic       frame_sequence;

  int mismatches;
  int outstanding;
  int results_checked;
  int verdicts_checked;
  int idle_pct;
  int stall_pct;
  int stall_left;
  int quiet_cycles;
  int bytes_sent;
  int frames_built;

  logic [7:0] line_bytes[$];

  stuffed_frame_receiver uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .payload_byte(payload_byte),
    .verdict(verdict),
    .reply_control(reply_control),
    .frame_sequence(frame_sequence)
  );

  frame_result_checker result_check (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .rx_byte(rx_byte),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .result_kind(result_kind),
    .payload_byte(payload_byte),
    .verdict(verdict),
    .reply_control(reply_control),
    .frame_sequence(frame_sequence),
    .mismatches(mismatches),
    .outstanding(outstanding),
    .results_checked(results_checked),
    .verdicts_checked(verdicts_checked)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic int pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 8;
      default: return 30;
    endcase
  endfunction

  // Body data leans on the bytes that need stuffing.
  function automatic logic [7:0] body_value();
    case ($urandom_range(7))
      0: return FLAG_BYTE;
      1: return ESC_BYTE;
      2: return $urandom_range(1) ? ESC_FLAG : ESC_ESC;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic void put_stuffed(input logic [7:0] b);
    if (b == FLAG_BYTE) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(ESC_FLAG);
    end else if (b == ESC_BYTE) begin
      line_bytes.push_back(ESC_BYTE);
      line_bytes.push_back(ESC_ESC);
    end else begin
      line_bytes.push_back(b);
    end
  endfunction

  function automatic void put_header(input logic seq);
    logic [7:0] ctrl;
    ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;
    line_bytes.push_back(FLAG_BYTE);
    case ($urandom_range(9))
      0: begin
        line_bytes.push_back(FLAG_BYTE);
      end
      1: begin
        line_bytes.push_back(ADDR_BYTE);
        line_bytes.push_back(FLAG_BYTE);
      end
      default: begin
      end
    endcase
    line_bytes.push_back(ADDR_BYTE);
    line_bytes.push_back(ctrl);
    line_bytes.push_back(ADDR_BYTE ^ ctrl);
  endfunction

  task automatic send_line_bytes();
    foreach (line_bytes[i]) begin
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
        in_valid <= 1'b0;
        repeat ($urandom_range(12, 1)) @(posedge clk);
      end
      in_valid <= 1'b1;
      rx_byte <= line_bytes[i];
      @(posedge clk);
      while (in_stall) @(posedge clk);
      bytes_sent++;
    end
    line_bytes.delete();
  endtask

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
      stall_left <= $urandom_range(11);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("Watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
    $display("Mismatches found");
    $finish;
  end

  initial begin
    logic [7:0] sum;
    logic [7:0] trailer;
    logic [7:0] junk;
    logic [7:0] ctrl;
    logic       seq;
    int         len;
    int         pick;
    frame_kind_e kind;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Repeated flags before address and control, escapes, extreme data,
    // then an empty body and an escape followed by a flag.
    line_bytes = '{FLAG_BYTE, FLAG_BYTE, ADDR_BYTE, FLAG_BYTE, ADDR_BYTE, CTRL_SEQ0,
                   ADDR_BYTE ^ CTRL_SEQ0, 8'h00, 8'hFF, ESC_BYTE, ESC_FLAG, ESC_BYTE,
                   ESC_ESC, 8'hFF ^ FLAG_BYTE ^ ESC_BYTE, FLAG_BYTE,
                   FLAG_BYTE, ADDR_BYTE, CTRL_SEQ1, ADDR_BYTE ^ CTRL_SEQ1, FLAG_BYTE,
                   FLAG_BYTE, ADDR_BYTE, CTRL_SEQ1, ADDR_BYTE ^ CTRL_SEQ1, ESC_BYTE,
                   FLAG_BYTE};
    send_line_bytes();

    while (bytes_sent < TOTAL_BYTES) begin
      if (bytes_sent >= QUIET_AFTER) begin
        idle_pct = 0;
        stall_pct <= 0;
      end else begin
        idle_pct = pick_idle_pct();
        stall_pct <= pick_idle_pct();
      end

      pick = $urandom_range(99);
      if (pick < 55) kind = FRM_GOOD;
      else if (pick < 65) kind = FRM_BAD_TRAILER;
      else if (pick < 72) kind = FRM_EMPTY;
      else if (pick < 79) kind = FRM_SINGLE;
      else if (pick < 86) kind = FRM_BAD_ESCAPE;
      else if (pick < 95) kind = FRM_BAD_HEADER;
      else kind = FRM_NOISE;

      seq = $urandom_range(1);
      ctrl = seq ? CTRL_SEQ1 : CTRL_SEQ0;

      case (kind)
        FRM_NOISE: begin
          repeat ($urandom_range(6, 1)) begin
            junk = $urandom;
            line_bytes.push_back(junk == FLAG_BYTE ? 8'h00 : junk);
          end
        end
        FRM_BAD_HEADER: begin
          line_bytes.push_back(FLAG_BYTE);
          case ($urandom_range(3))
            0: begin
              junk = $urandom;
              if (junk == ADDR_BYTE || junk == FLAG_BYTE) junk = ~junk;
              line_bytes.push_back(junk);
            end
            1: begin
              line_bytes.push_back(ADDR_BYTE);
              junk = $urandom;
              if (junk == CTRL_SEQ0 || junk == CTRL_SEQ1 || junk == FLAG_BYTE) junk ^= 8'h01;
              line_bytes.push_back(junk);
            end
            2: begin
              line_bytes.push_back(ADDR_BYTE);
              line_bytes.push_back(ctrl);
              junk = $urandom;
              if (junk == (ADDR_BYTE ^ ctrl)) junk ^= 8'h80;
              line_bytes.push_back(junk);
            end
            default: begin
              line_bytes.push_back(ADDR_BYTE);
              line_bytes.push_back(ctrl);
              line_bytes.push_back(FLAG_BYTE);
            end
          endcase
        end
        FRM_EMPTY: begin
          put_header(seq);
          line_bytes.push_back(FLAG_BYTE);
        end
        FRM_SINGLE: begin
          put_header(seq);
          trailer = $urandom_range(1) ? 8'h00 : 8'($urandom);
          put_stuffed(trailer);
          line_bytes.push_back(FLAG_BYTE);
        end
        FRM_BAD_ESCAPE: begin
          put_header(seq);
          repeat ($urandom_range(3)) put_stuffed(body_value());
          line_bytes.push_back(ESC_BYTE);
          junk = $urandom_range(3) == 0 ? FLAG_BYTE : 8'($urandom);
          if (junk == ESC_FLAG || junk == ESC_ESC) junk = FLAG_BYTE;
          line_bytes.push_back(junk);
        end
        default: begin
          put_header(seq);
          len = $urandom_range(15) == 0 ? $urandom_range(60, 20) : $urandom_range(8, 1);
          sum = 8'h00;
          repeat (len) begin
            junk = body_value();
            sum ^= junk;
            put_stuffed(junk);
          end
          trailer = sum;
          if (kind == FRM_BAD_TRAILER) trailer = sum ^ 8'($urandom_range(255, 1));
          put_stuffed(trailer);
          line_bytes.push_back(FLAG_BYTE);
        end
      endcase

      frames_built++;
      send_line_bytes();
    end

    in_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    repeat (8) @(posedge clk);

    $display("Sent %0d line bytes: a directed opening plus %0d random frames and noise runs.",
             bytes_sent, frames_built);
    $display("Checked %0d results, %0d of them end-of-frame verdicts.",
             results_checked, verdicts_checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
